FILE: hw/rtl/sclt_pkg.sv
// Package for the sector cache tag and replacement engine.
// Holds widths, defaults, command and state codes and the request/result types.
// No dependencies.
package sclt_pkg;

  localparam int unsigned WAYS_DEF        = 8;
  localparam int unsigned NUM_SECTORS_DEF = 1024;
  localparam int unsigned SECTOR_W        = 10;
  localparam int unsigned STAMP_W         = 32;
  localparam int unsigned WAY_OUT_W       = 3;
  localparam int unsigned ENTRY_W         = SECTOR_W + STAMP_W;
  localparam int unsigned IN_DATA_W       = 48;
  localparam int unsigned OUT_DATA_W      = 8;
  localparam int unsigned SEC_CMP_W       = 17;

  typedef enum logic [0:0] {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    cmd_e                cmd;
    logic [SECTOR_W-1:0] sector;
    logic [STAMP_W-1:0]  tick;
  } req_t;

  // packed lowest bit last: hit is bit 0
  typedef struct packed {
    logic                 invalidated;
    logic                 fetch_needed;
    logic [WAY_OUT_W-1:0] way;
    logic                 hit;
  } res_t;

endpackage

FILE: hw/rtl/sclt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sclt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: hw/rtl/sclt_ctrl.sv
// Request sequencer: scans the tag RAM way by way, tracks hit, first free way
// and oldest stamp, writes back reads and returns the result. Uses sclt_pkg.
module sclt_ctrl #(
  parameter int unsigned WAYS        = sclt_pkg::WAYS_DEF,
  parameter int unsigned NUM_SECTORS = sclt_pkg::NUM_SECTORS_DEF,
  localparam int unsigned WayW       = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_vld_i,
  output logic                         req_rdy_o,
  input  sclt_pkg::req_t               req_i,
  output logic                         res_vld_o,
  input  logic                         res_rdy_i,
  output sclt_pkg::res_t               res_o,
  output logic                         ram_rd_en_o,
  output logic [WayW-1:0]              ram_rd_addr_o,
  input  logic [sclt_pkg::ENTRY_W-1:0] ram_rd_data_i,
  output logic                         ram_wr_en_o,
  output logic [WayW-1:0]              ram_wr_addr_o,
  output logic [sclt_pkg::ENTRY_W-1:0] ram_wr_data_o
);
  import sclt_pkg::*;

  localparam logic [WayW-1:0] LastWay = WayW'(WAYS - 1);

  state_e state_q, state_d;
  logic [WayW-1:0] cnt_q, cnt_d;
  logic cmp_vld_q;
  logic [WayW-1:0] cmp_idx_q;
  logic [WAYS-1:0] valid_q;
  req_t req_q;
  logic oor_q;
  logic hit_q, free_q, killed_q;
  logic [WayW-1:0] hit_way_q, free_way_q, min_way_q;
  logic [STAMP_W-1:0] min_q;

  logic accept, match;
  logic [SECTOR_W-1:0] rd_sector;
  logic [STAMP_W-1:0] rd_stamp;
  logic [WayW-1:0] fill_way;
  logic [WayW+WAY_OUT_W-1:0] way_ext;
  logic oor_in;

  assign rd_sector = ram_rd_data_i[ENTRY_W-1:STAMP_W];
  assign rd_stamp  = ram_rd_data_i[STAMP_W-1:0];
  assign match     = cmp_vld_q && valid_q[cmp_idx_q] && (rd_sector == req_q.sector);
  assign oor_in    = {{(SEC_CMP_W-SECTOR_W){1'b0}}, req_i.sector} >= SEC_CMP_W'(NUM_SECTORS);
  assign accept    = req_vld_i && req_rdy_o;
  assign fill_way  = hit_q ? hit_way_q : (free_q ? free_way_q : min_way_q);
  assign way_ext   = {{WAY_OUT_W{1'b0}}, fill_way};

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    req_rdy_o   = 1'b0;
    res_vld_o   = 1'b0;
    ram_rd_en_o = 1'b0;
    ram_wr_en_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_rdy_o = 1'b1;
        cnt_d     = '0;
        if (req_vld_i) begin
          state_d = oor_in ? ST_UPDATE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        ram_rd_en_o = 1'b1;
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == LastWay) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        res_vld_o = 1'b1;
        if (res_rdy_i) begin
          ram_wr_en_o = !oor_q && (req_q.cmd == CMD_READ);
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign ram_rd_addr_o = cnt_q;
  assign ram_wr_addr_o = fill_way;
  assign ram_wr_data_o = {req_q.sector, req_q.tick};

  always_comb begin
    res_o = '0;
    if (!oor_q) begin
      if (req_q.cmd == CMD_WRITE) begin
        res_o.invalidated = killed_q;
      end else begin
        res_o.hit          = hit_q;
        res_o.way          = way_ext[WAY_OUT_W-1:0];
        res_o.fetch_needed = !hit_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
      valid_q   <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cmp_vld_q <= (state_q == ST_SCAN);
      cmp_idx_q <= cnt_q;
      if (match && (req_q.cmd == CMD_WRITE)) begin
        valid_q[cmp_idx_q] <= 1'b0;
      end
      if (ram_wr_en_o && !hit_q) begin
        valid_q[fill_way] <= 1'b1;
      end
    end
  end

  // scan results, seeded on accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q    <= req_i;
      oor_q    <= oor_in;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
      killed_q <= 1'b0;
    end else if (cmp_vld_q) begin
      if (req_q.cmd == CMD_WRITE) begin
        if (match) begin
          killed_q <= 1'b1;
        end
      end else begin
        if (match && !hit_q) begin
          hit_q     <= 1'b1;
          hit_way_q <= cmp_idx_q;
        end
        if (!valid_q[cmp_idx_q] && !free_q) begin
          free_q     <= 1'b1;
          free_way_q <= cmp_idx_q;
        end
        if ((cmp_idx_q == '0) || (rd_stamp < min_q)) begin
          min_q     <= rd_stamp;
          min_way_q <= cmp_idx_q;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/sector_cache_lru_tags_unit.sv
// Top level of the sector cache tag and LRU replacement engine.
// Instantiates sclt_ctrl and sclt_ram; uses sclt_pkg.
//
// Usage:
//   Requests enter on the s_axis channel: tuser is the command (read or
//   write), tdata carries sector and tick. Results leave on m_axis, one
//   per request, in request order.
//   A read hit refreshes the way's stamp; a read miss fills the first free
//   way, else the way with the oldest stamp, and flags fetch_needed. A write
//   invalidates every way holding the sector.
//   The tag RAM is scanned one way per cycle; the result passes the scan,
//   the last compare and the output register, and the next request is
//   taken only once the result has entered the output register. A sector
//   beyond the range skips the scan and gets an all-zero result.
//   Reset clears all valid bits at once (flip-flops); the block is ready in
//   the first cycle after reset.
//   When m_axis stalls, one result waits in the output register and the
//   next request is still accepted and scanned; it waits for the register
//   to drain before writing back.
module sector_cache_lru_tags_unit #(
  parameter int unsigned WAYS        = sclt_pkg::WAYS_DEF,
  parameter int unsigned NUM_SECTORS = sclt_pkg::NUM_SECTORS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // sector [9:0], tick [41:10], zero [47:42]
  input  logic [sclt_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // command [0]
  input  logic                            s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // hit [0], way [3:1], fetch_needed [4], invalidated [5], zero [7:6]
  output logic [sclt_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import sclt_pkg::*;

  localparam int unsigned WayW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned ResW = $bits(res_t);

  req_t req;
  res_t res;
  logic res_vld, res_rdy;
  logic ram_rd_en, ram_wr_en;
  logic [WayW-1:0] ram_rd_addr, ram_wr_addr;
  logic [ENTRY_W-1:0] ram_rd_data, ram_wr_data;
  logic out_vld_q;
  res_t out_q;

  assign req.cmd    = cmd_e'(s_axis_tuser_i);
  assign req.sector = s_axis_tdata_i[SECTOR_W-1:0];
  assign req.tick   = s_axis_tdata_i[ENTRY_W-1:SECTOR_W];

  sclt_ctrl #(
    .WAYS        (WAYS),
    .NUM_SECTORS (NUM_SECTORS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_vld_i     (s_axis_tvalid_i),
    .req_rdy_o     (s_axis_tready_o),
    .req_i         (req),
    .res_vld_o     (res_vld),
    .res_rdy_i     (res_rdy),
    .res_o         (res),
    .ram_rd_en_o   (ram_rd_en),
    .ram_rd_addr_o (ram_rd_addr),
    .ram_rd_data_i (ram_rd_data),
    .ram_wr_en_o   (ram_wr_en),
    .ram_wr_addr_o (ram_wr_addr),
    .ram_wr_data_o (ram_wr_data)
  );

  sclt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (WAYS)
  ) u_tag_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  assign res_rdy = !out_vld_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_vld && res_rdy) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld && res_rdy) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W-ResW){1'b0}}, out_q};

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("engine took a request while busy");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_vld && m_axis_tvalid_o && !m_axis_tready_i && res_rdy))
    else $error("output register overwritten while stalled");

  a_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[4] && (m_axis_tdata_o[0] || m_axis_tdata_o[5])))
    else $error("fetch flagged together with hit or invalidate");

  a_wb_on_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_wr_en |=> m_axis_tvalid_o)
    else $error("tag write-back without a delivered result");
`endif

endmodule
